>>> rtl/pfab_pkg.sv
// ----------------------------------------------------------------------------
// pfab_pkg
// Shared types, codes and helper functions of the pixel blend pipeline.
// ----------------------------------------------------------------------------
package pfab_pkg;

   // Pixel layouts, as seen by the unpacker
   localparam logic [1:0] FMT_RGB565   = 2'd0;
   localparam logic [1:0] FMT_RGB888   = 2'd1;
   localparam logic [1:0] FMT_ARGB8565 = 2'd2;
   localparam logic [1:0] FMT_ARGB8888 = 2'd3;

   // Destination layouts
   localparam logic [1:0] DEST_RGB565   = 2'd0;
   localparam logic [1:0] DEST_RGB888   = 2'd1;
   localparam logic [1:0] DEST_ARGB8888 = 2'd2;
   localparam logic [1:0] DEST_UNUSED   = 2'd3;

   // Blend modes
   localparam logic [2:0] BLEND_COVER       = 3'd0;
   localparam logic [2:0] BLEND_BYPASS      = 3'd1;
   localparam logic [2:0] BLEND_FILTER_BLACK = 3'd2;
   localparam logic [2:0] BLEND_SOURCE_OVER = 3'd3;

   // Register indexes
   localparam logic [1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [1:0] CSR_DEST_FORMAT   = 2'd1;
   localparam logic [1:0] CSR_BLEND_SELECT  = 2'd2;
   localparam logic [1:0] CSR_OPACITY       = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } chan_type;

   typedef struct packed {
      logic [15:0] a;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
   } sum_type;

   typedef enum logic [1:0] {
      SEL_SOURCE,
      SEL_DEST,
      SEL_MIX,
      SEL_RAW
   } sel_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   typedef struct packed {
      chan_type    src;
      chan_type    dst;
      logic [7:0]  mix_alpha;
      logic [7:0]  alpha_src;
      sel_type     sel;
      logic [31:0] dest_raw;
   } front_out_type;

   // Split a packed word into 8-bit channels; narrow fields are left-shifted.
   function automatic chan_type unpack_pixel(input logic [31:0] w, input logic [1:0] fmt);
      chan_type c;
      unique case (fmt)
         FMT_RGB565: begin
            c.a = ALPHA_OPAQUE;
            c.r = {w[15:11], 3'b000};
            c.g = {w[10:5], 2'b00};
            c.b = {w[4:0], 3'b000};
         end
         FMT_RGB888: begin
            c.a = ALPHA_OPAQUE;
            c.r = w[23:16];
            c.g = w[15:8];
            c.b = w[7:0];
         end
         FMT_ARGB8565: begin
            c.a = w[23:16];
            c.r = {w[15:11], 3'b000};
            c.g = {w[10:5], 2'b00};
            c.b = {w[4:0], 3'b000};
         end
         default: begin
            c.a = w[31:24];
            c.r = w[23:16];
            c.g = w[15:8];
            c.b = w[7:0];
         end
      endcase
      return c;
   endfunction

   // Truncating x / 255, exact for x up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // (255 - a) * t + a * s, never above 255 * 255.
   function automatic logic [15:0] mix_sum(input logic [7:0] t, input logic [7:0] s,
                                           input logic [7:0] a);
      logic [7:0] inv;
      inv = 8'd255 - a;
      return ({8'd0, inv} * {8'd0, t}) + ({8'd0, a} * {8'd0, s});
   endfunction

endpackage

>>> rtl/pfab_req_if.sv
// ----------------------------------------------------------------------------
// pfab_req_if
// Request channel: one source word and one destination word per item.
// ----------------------------------------------------------------------------
interface pfab_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_pixel;
   logic [31:0] dest_pixel;

   modport source (output valid, output source_pixel, output dest_pixel, input ready);
   modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

>>> rtl/pfab_rsp_if.sv
// ----------------------------------------------------------------------------
// pfab_rsp_if
// Response channel: one blended destination word per item.
// ----------------------------------------------------------------------------
interface pfab_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_pixel;

   modport source (output valid, output result_pixel, input ready);
   modport sink   (input valid, input result_pixel, output ready);
endinterface

>>> rtl/pfab_front.sv
// ----------------------------------------------------------------------------
// pfab_front
// Stages 1 and 2: unpack both words, scale source alpha, pick blend alpha.
// ----------------------------------------------------------------------------
module pfab_front import pfab_pkg::*; (
   input  logic          clock,
   input  stage_en_type  en,
   input  logic [31:0]   source_pixel,
   input  logic [31:0]   dest_pixel,
   input  logic [1:0]    source_format,
   input  logic [1:0]    dest_format,
   input  logic [2:0]    blend_select,
   input  logic [7:0]    opacity,
   output front_out_type mid
);

   chan_type      s1_src_ff, s1_src_in;
   chan_type      s1_dst_ff, s1_dst_in;
   logic [15:0]   s1_prod_ff, s1_prod_in;
   logic          s1_black_ff, s1_black_in;
   logic [31:0]   s1_raw_ff;
   front_out_type s2_ff, s2_in;
   logic [1:0]    dst_fmt;
   logic [7:0]    ea;

   // Stage 1: unpack, alpha times opacity, black source check
   always_comb begin
      unique case (dest_format)
         DEST_RGB565: dst_fmt = FMT_RGB565;
         DEST_RGB888: dst_fmt = FMT_RGB888;
         default:     dst_fmt = FMT_ARGB8888;
      endcase
      s1_src_in   = unpack_pixel(source_pixel, source_format);
      s1_dst_in   = unpack_pixel(dest_pixel, dst_fmt);
      s1_prod_in  = {8'd0, s1_src_in.a} * {8'd0, opacity};
      s1_black_in = (s1_src_in.r == 8'd0) && (s1_src_in.g == 8'd0) && (s1_src_in.b == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_src_ff   <= s1_src_in;
         s1_dst_ff   <= s1_dst_in;
         s1_prod_ff  <= s1_prod_in;
         s1_black_ff <= s1_black_in;
         s1_raw_ff   <= dest_pixel;
      end
   end

   // Stage 2: effective alpha and channel select
   always_comb begin
      ea              = div255(s1_prod_ff);
      s2_in.src       = s1_src_ff;
      s2_in.dst       = s1_dst_ff;
      s2_in.dest_raw  = s1_raw_ff;
      s2_in.mix_alpha = ea;
      s2_in.alpha_src = ea;
      s2_in.sel       = SEL_DEST;
      if (dest_format == DEST_UNUSED) begin
         s2_in.sel = SEL_RAW;
      end else begin
         unique case (blend_select)
            BLEND_COVER: s2_in.sel = SEL_SOURCE;
            BLEND_BYPASS: begin
               s2_in.sel       = SEL_MIX;
               s2_in.mix_alpha = opacity;
               s2_in.alpha_src = s1_src_ff.a;
            end
            BLEND_FILTER_BLACK: s2_in.sel = s1_black_ff ? SEL_DEST : SEL_MIX;
            BLEND_SOURCE_OVER:  s2_in.sel = SEL_MIX;
            default:            s2_in.sel = SEL_DEST;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         s2_ff <= s2_in;
      end
   end

   assign mid = s2_ff;

endmodule

>>> rtl/pfab_back.sv
// ----------------------------------------------------------------------------
// pfab_back
// Stages 3 and 4: weighted channel sums, divide by 255, select and pack.
// ----------------------------------------------------------------------------
module pfab_back import pfab_pkg::*; (
   input  logic          clock,
   input  stage_en_type  en,
   input  front_out_type mid,
   input  logic [1:0]    dest_format,
   output logic [31:0]   result_pixel
);

   sum_type     s3_sum_ff, s3_sum_in;
   chan_type    s3_src_ff;
   chan_type    s3_dst_ff;
   sel_type     s3_sel_ff;
   logic [31:0] s3_raw_ff;
   logic [31:0] s4_result_ff, s4_result_in;
   chan_type    mixed;
   chan_type    pick;

   // Stage 3: one multiply-add per channel
   always_comb begin
      s3_sum_in.a = mix_sum(mid.dst.a, mid.alpha_src, mid.mix_alpha);
      s3_sum_in.r = mix_sum(mid.dst.r, mid.src.r, mid.mix_alpha);
      s3_sum_in.g = mix_sum(mid.dst.g, mid.src.g, mid.mix_alpha);
      s3_sum_in.b = mix_sum(mid.dst.b, mid.src.b, mid.mix_alpha);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         s3_sum_ff <= s3_sum_in;
         s3_src_ff <= mid.src;
         s3_dst_ff <= mid.dst;
         s3_sel_ff <= mid.sel;
         s3_raw_ff <= mid.dest_raw;
      end
   end

   // Stage 4: divide, select, repack
   always_comb begin
      mixed.a = div255(s3_sum_ff.a);
      mixed.r = div255(s3_sum_ff.r);
      mixed.g = div255(s3_sum_ff.g);
      mixed.b = div255(s3_sum_ff.b);
      unique case (s3_sel_ff)
         SEL_SOURCE: pick = s3_src_ff;
         SEL_MIX:    pick = mixed;
         default:    pick = s3_dst_ff;
      endcase
      if (s3_sel_ff == SEL_RAW) begin
         s4_result_in = s3_raw_ff;
      end else begin
         unique case (dest_format)
            DEST_RGB565:
               s4_result_in = {16'd0, pick.r[7:3], pick.g[7:2], pick.b[7:3]};
            DEST_RGB888:
               s4_result_in = {8'd0, pick.r, pick.g, pick.b};
            DEST_ARGB8888:
               s4_result_in = {pick.a, pick.r, pick.g, pick.b};
            default:
               s4_result_in = s3_raw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         s4_result_ff <= s4_result_in;
      end
   end

   assign result_pixel = s4_result_ff;

endmodule

>>> rtl/pixel_format_alpha_blend_unit.sv
// ----------------------------------------------------------------------------
// pixel_format_alpha_blend_unit
// Pixel compositor: converts formats, blends one pixel a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  - req_stream carries one item per handshake: a source word and the current
//    destination word. rsp_stream returns the new destination word.
//  - csr_* writes source_format, dest_format, blend_select and opacity by
//    index. Write them only while no item is in flight.
//  - Each item passes four register stages on its way to rsp valid: unpack and
//    alpha multiply, alpha divide and mode select, channel multiply-add,
//    channel divide and repack.
//  - Throughput is one item per cycle while the receiver is ready; the four
//    register stages, each with its own valid bit, overlap successive items.
//  - When the receiver stalls, the output register holds its item and the
//    stall moves back stage by stage: empty stages still fill, so the block
//    keeps taking items until every stage holds one.
//  - Reset empties the pipeline and loads the register defaults (argb8888
//    source, rgb565 destination, source over, opacity 255).
// ----------------------------------------------------------------------------
module pixel_format_alpha_blend_unit import pfab_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pfab_req_if.sink    req_stream,
   pfab_rsp_if.source  rsp_stream,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   logic [1:0]    source_format_ff;
   logic [1:0]    dest_format_ff;
   logic [2:0]    blend_select_ff;
   logic [7:0]    opacity_ff;

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic          ready1, ready2, ready3, ready4;
   stage_en_type  en;
   front_out_type mid;
   logic [31:0]   result_pixel;

   // Configuration registers: take the low bits of the write data
   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= FMT_ARGB8888;
         dest_format_ff   <= DEST_RGB565;
         blend_select_ff  <= BLEND_SOURCE_OVER;
         opacity_ff       <= ALPHA_OPAQUE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOURCE_FORMAT: source_format_ff <= csr_write_data[1:0];
            CSR_DEST_FORMAT:   dest_format_ff   <= csr_write_data[1:0];
            CSR_BLEND_SELECT:  blend_select_ff  <= csr_write_data[2:0];
            default:           opacity_ff       <= csr_write_data;
         endcase
      end
   end

   // A stage loads when it is empty or its successor moves on
   assign ready4 = !v4_ff || rsp_stream.ready;
   assign ready3 = !v3_ff || ready4;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;

   assign en.s1 = ready1;
   assign en.s2 = ready2;
   assign en.s3 = ready3;
   assign en.s4 = ready4;

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_stream.valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   pfab_front u_front (
      .clock         (clock),
      .en            (en),
      .source_pixel  (req_stream.source_pixel),
      .dest_pixel    (req_stream.dest_pixel),
      .source_format (source_format_ff),
      .dest_format   (dest_format_ff),
      .blend_select  (blend_select_ff),
      .opacity       (opacity_ff),
      .mid           (mid)
   );

   pfab_back u_back (
      .clock        (clock),
      .en           (en),
      .mid          (mid),
      .dest_format  (dest_format_ff),
      .result_pixel (result_pixel)
   );

   assign req_stream.ready        = ready1;
   assign rsp_stream.valid        = v4_ff;
   assign rsp_stream.result_pixel = result_pixel;

   // An accepted item lands in stage 1
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_stream.valid && req_stream.ready) |=> v1_ff)
      else $error("accepted item missing from stage 1");

   // A blocked stage keeps its item
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !ready2) |=> v1_ff)
      else $error("stage 1 item lost under stall");

   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !ready4) |=> v3_ff)
      else $error("stage 3 item lost under stall");

   // With the output stage empty, nothing may block the request side
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !v4_ff |-> req_stream.ready)
      else $error("request side stalled with empty output stage");

endmodule

>>> sim/pixel_format_alpha_blend_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_format_alpha_blend_unit_test
// Self-checking bench for the pixel blend unit. A directed pass covers every
// blend mode, the opacity extremes, every source and destination layout and
// the unused destination layout. A random pass then runs many register
// settings with random pixel words and random gaps and stalls on both
// channels. Every result is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module pixel_format_alpha_blend_unit_test;
   import pfab_pkg::*;

   // The package names modes 0 to 3 only; 4 and up keep the destination.
   localparam logic [2:0] BLEND_KEEP = 3'd4;
   localparam int PIPE_DEPTH  = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_COUNT = 23;
   localparam int PHASE_ITEMS = 50;

   // One pixel split into 8-bit channels, packed in argb8888 order.
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgba_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   pfab_req_if pixel_req();
   pfab_rsp_if pixel_rsp();

   pixel_format_alpha_blend_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (pixel_req),
      .rsp_stream       (pixel_rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the block's registers, as last written.
   logic [1:0] src_layout;
   logic [1:0] dst_layout;
   logic [2:0] blend_code;
   logic [7:0] opacity_level;

   // Predicted result words, oldest first.
   logic [31:0] pending_pixels[$];
   logic [31:0] wanted_pixel;

   int          error_count = 0;
   int          cycle_count = 0;
   bit          gaps_on = 1'b0;
   int unsigned stall_left = 0;

   // Free-running clock, 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Split a packed word into channels; widen narrow fields by a shift only.
   function automatic rgba_type split_word(input logic [31:0] word, input logic [1:0] layout);
      rgba_type c;
      case (layout)
         FMT_RGB565: begin
            c.alpha = ALPHA_OPAQUE;
            c.red   = {word[15:11], 3'b000};
            c.green = {word[10:5], 2'b00};
            c.blue  = {word[4:0], 3'b000};
         end
         FMT_RGB888: begin
            c.alpha = ALPHA_OPAQUE;
            c.red   = word[23:16];
            c.green = word[15:8];
            c.blue  = word[7:0];
         end
         FMT_ARGB8565: begin
            c.alpha = word[23:16];
            c.red   = {word[15:11], 3'b000};
            c.green = {word[10:5], 2'b00};
            c.blue  = {word[4:0], 3'b000};
         end
         default: begin
            c = word;
         end
      endcase
      return c;
   endfunction

   // ((255 - a) * under + a * over) / 255, truncated.
   function automatic logic [7:0] weigh(input logic [7:0] under, input logic [7:0] over,
                                        input logic [7:0] a);
      int unsigned total;
      total = (32'd255 - 32'(a)) * 32'(under) + 32'(a) * 32'(over);
      return 8'(total / 32'd255);
   endfunction

   function automatic rgba_type weigh_all(input rgba_type under, input rgba_type over,
                                          input logic [7:0] a, input logic [7:0] alpha_in);
      rgba_type c;
      c.alpha = weigh(under.alpha, alpha_in, a);
      c.red   = weigh(under.red, over.red, a);
      c.green = weigh(under.green, over.green, a);
      c.blue  = weigh(under.blue, over.blue, a);
      return c;
   endfunction

   // New destination word for one source/destination pair under the shadow registers.
   function automatic logic [31:0] predict_pixel(input logic [31:0] src_word,
                                                 input logic [31:0] dst_word);
      rgba_type   src;
      rgba_type   dst;
      logic [1:0] dst_as_src;
      logic [7:0] eff_alpha;
      if (dst_layout == DEST_UNUSED) return dst_word;
      case (dst_layout)
         DEST_RGB565: dst_as_src = FMT_RGB565;
         DEST_RGB888: dst_as_src = FMT_RGB888;
         default:     dst_as_src = FMT_ARGB8888;
      endcase
      src       = split_word(src_word, src_layout);
      dst       = split_word(dst_word, dst_as_src);
      eff_alpha = 8'((32'(src.alpha) * 32'(opacity_level)) / 32'd255);
      case (blend_code)
         BLEND_COVER:  dst = src;
         BLEND_BYPASS: dst = weigh_all(dst, src, opacity_level, src.alpha);
         BLEND_FILTER_BLACK: begin
            // Keep the destination under a black source.
            if (src.red != 8'd0 || src.green != 8'd0 || src.blue != 8'd0)
               dst = weigh_all(dst, src, eff_alpha, eff_alpha);
         end
         BLEND_SOURCE_OVER: dst = weigh_all(dst, src, eff_alpha, eff_alpha);
         default: ;
      endcase
      case (dst_layout)
         DEST_RGB565: return {16'd0, dst.red[7:3], dst.green[7:2], dst.blue[7:3]};
         DEST_RGB888: return {8'd0, dst.red, dst.green, dst.blue};
         default:     return dst;
      endcase
   endfunction

   // Random pixel word, biased toward all-zero, all-one, black and opaque words.
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 9))
         0: w = 32'h0000_0000;
         1: w = 32'hFFFF_FFFF;
         2: w[23:0] = 24'd0;
         3: w[15:0] = 16'd0;
         4: w[31:24] = 8'hFF;
         default: ;
      endcase
      return w;
   endfunction

   // Offer one item, hold it until accepted, then record its prediction.
   task automatic send_pixel(input logic [31:0] src_word, input logic [31:0] dst_word);
      int unsigned gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         pixel_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pixel_req.valid        <= 1'b1;
      pixel_req.source_pixel <= src_word;
      pixel_req.dest_pixel   <= dst_word;
      do @(posedge clock); while (pixel_req.ready !== 1'b1);
      pending_pixels.push_back(predict_pixel(src_word, dst_word));
   endtask

   // Drop valid, wait for every result, then let the pipeline settle.
   task automatic drain_pipeline();
      pixel_req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_SOURCE_FORMAT: src_layout    = value[1:0];
         CSR_DEST_FORMAT:   dst_layout    = value[1:0];
         CSR_BLEND_SELECT:  blend_code    = value[2:0];
         default:           opacity_level = value;
      endcase
   endtask

   // Reprogram all four registers with the pipeline empty.
   task automatic apply_settings(input logic [1:0] src_fmt, input logic [1:0] dst_fmt,
                                 input logic [2:0] mode, input logic [7:0] level);
      drain_pipeline();
      write_register(CSR_SOURCE_FORMAT, {6'd0, src_fmt});
      write_register(CSR_DEST_FORMAT, {6'd0, dst_fmt});
      write_register(CSR_BLEND_SELECT, {5'd0, mode});
      write_register(CSR_OPACITY, level);
   endtask

   // Reset defaults: argb8888 source, rgb565 destination, source over, opacity 255.
   task automatic test_reset_defaults();
      gaps_on = 1'b0;
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(32'h80C0_4020, 32'h0000_A5A5);
   endtask

   // Every 3-bit blend code, modes 4 to 7 keeping the destination.
   task automatic test_blend_modes();
      for (int mode = 0; mode < 8; mode++) begin
         apply_settings(FMT_ARGB8888, DEST_ARGB8888, 3'(mode), 8'h80);
         send_pixel(32'h9CE0_4018, 32'h3020_F080);
         // A black source must leave the destination alone in filter mode.
         if (3'(mode) == BLEND_FILTER_BLACK) send_pixel(32'hFF00_0000, 32'h3020_F080);
      end
   endtask

   task automatic test_opacity_extremes();
      apply_settings(FMT_ARGB8888, DEST_ARGB8888, BLEND_BYPASS, 8'h00);
      send_pixel(32'h1122_3344, 32'hCCDD_EEFF);
      apply_settings(FMT_ARGB8888, DEST_ARGB8888, BLEND_BYPASS, 8'hFF);
      send_pixel(32'h1122_3344, 32'hCCDD_EEFF);
   endtask

   // Narrow source layouts, bits above a layout, the unused destination layout.
   task automatic test_formats();
      apply_settings(FMT_RGB565, DEST_ARGB8888, BLEND_COVER, 8'hFF);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      apply_settings(FMT_RGB888, DEST_ARGB8888, BLEND_COVER, 8'hFF);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      apply_settings(FMT_ARGB8565, DEST_ARGB8888, BLEND_COVER, 8'hFF);
      send_pixel(32'h5A7F_F81F, 32'h0000_0000);
      apply_settings(FMT_ARGB8888, DEST_RGB888, BLEND_KEEP, 8'hFF);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      apply_settings(FMT_ARGB8888, DEST_UNUSED, BLEND_SOURCE_OVER, 8'h40);
      send_pixel(32'h8012_3456, 32'hDEAD_BEEF);
   endtask

   // Random settings per phase, random words, gaps on most phases.
   task automatic test_random_settings();
      logic [1:0] src_fmt;
      logic [1:0] dst_fmt;
      logic [2:0] mode;
      logic [7:0] level;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         src_fmt = 2'($urandom_range(int'(FMT_RGB565), int'(FMT_ARGB8888)));
         dst_fmt = ($urandom_range(0, 9) == 0) ? DEST_UNUSED :
                   2'($urandom_range(int'(DEST_RGB565), int'(DEST_ARGB8888)));
         mode    = ($urandom_range(0, 9) < 2) ? 3'($urandom_range(int'(BLEND_KEEP), 7)) :
                   3'($urandom_range(int'(BLEND_COVER), int'(BLEND_SOURCE_OVER)));
         case ($urandom_range(0, 3))
            0:       level = 8'h00;
            1:       level = 8'hFF;
            default: level = 8'($urandom_range(0, 255));
         endcase
         apply_settings(src_fmt, dst_fmt, mode, level);
         gaps_on = ($urandom_range(0, 4) != 0);
         repeat (PHASE_ITEMS) send_pixel(random_word(), random_word());
      end
   endtask

   // Receiver: stall at random while gaps are on; otherwise ready once a running stall ends.
   initial begin
      pixel_rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            pixel_rsp.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
            pixel_rsp.ready <= 1'b0;
         end else begin
            pixel_rsp.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && pixel_rsp.valid === 1'b1 && pixel_rsp.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h",
                     $time, pixel_rsp.result_pixel);
         end else begin
            wanted_pixel = pending_pixels.pop_front();
            if (pixel_rsp.result_pixel !== wanted_pixel) begin
               error_count++;
               $display("%0t: result_pixel mismatch, expected %h, actual %h",
                        $time, wanted_pixel, pixel_rsp.result_pixel);
            end
         end
      end
   end

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      // Drive every input to a known value and hold reset, then release it.
      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_index              <= CSR_SOURCE_FORMAT;
      csr_write_data         <= 8'd0;
      pixel_req.valid        <= 1'b0;
      pixel_req.source_pixel <= 32'd0;
      pixel_req.dest_pixel   <= 32'd0;
      src_layout    = FMT_ARGB8888;
      dst_layout    = DEST_RGB565;
      blend_code    = BLEND_SOURCE_OVER;
      opacity_level = 8'hFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_blend_modes();
      test_opacity_extremes();
      test_formats();
      test_random_settings();

      // Wait out the last results before the verdict.
      drain_pipeline();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> pixel_format_alpha_blend_unit.f
rtl/pfab_pkg.sv
rtl/pfab_req_if.sv
rtl/pfab_rsp_if.sv
rtl/pfab_front.sv
rtl/pfab_back.sv
rtl/pixel_format_alpha_blend_unit.sv
sim/pixel_format_alpha_blend_unit_test.sv
